// ===== sv/utf8_to_utf16_decoder_unit_assert.svh =====
// Assertion macros shared by the decoder modules.
// Each macro takes a label, clock, active-low reset, a condition (or an antecedent and a consequent) and a message.
`ifndef UTF8_TO_UTF16_DECODER_UNIT_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define U8U16_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define U8U16_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/u8u16_pkg.sv =====
`timescale 1ns / 1ps

package u8u16_pkg;

    // Largest number of code units that one input byte can produce.
    localparam int unsigned MAX_UNITS = 4;

    // Sequence lengths.
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // Surrogate prefixes (upper six bits of a surrogate code unit).
    localparam logic [5:0] SURR_HI_PREFIX = 6'b110110;
    localparam logic [5:0] SURR_LO_PREFIX = 6'b110111;

    // Offset removed from a supplementary code point.
    localparam logic [20:0] SUPP_OFFSET = 21'h10000;

    // Code units produced by one byte, in output order.
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [2:0]                 count;
    } t_result;

endpackage

// ===== sv/utf8_to_utf16_decoder_unit.sv =====
`timescale 1ns / 1ps

// UTF-8 to UTF-16 decoder. Bytes enter on the s_axis side, one per transfer, and
// UTF-16 code units leave on the m_axis side. ASCII bytes pass straight through;
// two-, three- and four-byte sequences become one code unit, or a high/low
// surrogate pair for four bytes. Malformed bytes (stray continuation bytes,
// 0xF8 to 0xFF, or the held bytes of a sequence broken by a non-continuation
// byte) come out as raw units with the byte zero-extended. No overlong or
// range checks are made. s_axis_tlast marks the final byte of the input; any
// sequence still open after it is flushed raw. m_axis_tlast is high on the last
// code unit caused by a given input byte; a byte that only extends an open
// sequence produces no transfer at all.
// Timing: a byte is registered at the input, decoded combinationally against
// the sequence state, and its code units are loaded into a four-entry output
// buffer at the edge where the buffer has room. The first unit is offered on
// m_axis from that buffer, after the input register and the buffer register.
// The output buffer sends one unit per cycle while m_axis_tready is high,
// which sets the rate: a byte that yields several units holds the input
// until the buffer is sending its last unit. s_axis_tready depends on
// m_axis_tready in the same cycle when the buffer is sending its last unit.

module utf8_to_utf16_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tlast    // last_of_run
);

    // Input register: one byte waiting for decode.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eoi;

    logic               w_can_load;
    logic               w_fire;
    u8u16_pkg::t_result w_res;

    // The decoder consumes the registered byte once the output buffer has room.
    assign w_fire        = r_in_valid && w_can_load;
    assign s_axis_tready = !r_in_valid || w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eoi  <= s_axis_tlast;
        end
    end

    // Sequence state and decode of one byte into up to four code units.
    u8u16_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .o_res   (w_res)
    );

    // Result buffer that sends the code units one transfer at a time.
    u8u16_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_res      (w_res),
        .i_ready    (m_axis_tready),
        .o_can_load (w_can_load),
        .o_valid    (m_axis_tvalid),
        .o_unit     (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

endmodule

// ===== sv/u8u16_core.sv =====
`timescale 1ns / 1ps
`include "utf8_to_utf16_decoder_unit_assert.svh"

module u8u16_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    input  logic                i_eoi,
    output u8u16_pkg::t_result  o_res
);

    logic [2:0][7:0] r_held;
    logic [1:0]      r_hc;
    logic [2:0]      r_el;

    logic [2:0][7:0] n_held;
    logic [1:0]      n_hc;
    logic [2:0]      n_el;

    logic [3:0][15:0] w_units;
    logic [2:0]       w_cnt;
    logic             w_cont;
    logic [20:0]      w_code;
    logic [20:0]      w_off;

    assign w_cont = (i_byte[7:6] == 2'b10);
    assign w_code = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0], i_byte[5:0]};
    assign w_off  = w_code - u8u16_pkg::SUPP_OFFSET;

    always_comb begin
        n_held  = r_held;
        n_hc    = r_hc;
        n_el    = r_el;
        w_units = '0;
        w_cnt   = 3'd0;

        if (r_hc != 2'd0 && w_cont) begin
            if (({1'b0, r_hc} + 3'd1) >= r_el) begin
                if (r_el == u8u16_pkg::LEN_2) begin
                    w_units[0] = {5'b0, r_held[0][4:0], i_byte[5:0]};
                    w_cnt      = 3'd1;
                end else if (r_el == u8u16_pkg::LEN_3) begin
                    w_units[0] = {r_held[0][3:0], r_held[1][5:0], i_byte[5:0]};
                    w_cnt      = 3'd1;
                end else begin
                    w_units[0] = {u8u16_pkg::SURR_HI_PREFIX, w_off[19:10]};
                    w_units[1] = {u8u16_pkg::SURR_LO_PREFIX, w_code[9:0]};
                    w_cnt      = 3'd2;
                end
                n_hc = 2'd0;
                n_el = u8u16_pkg::LEN_NONE;
            end else if (r_hc < 2'd3) begin
                n_held[r_hc] = i_byte;
                n_hc         = r_hc + 2'd1;
            end
        end else begin
            // A broken sequence releases its held bytes as raw units first.
            if (r_hc != 2'd0) begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < r_hc && w_cnt < 3'd4) begin
                        w_units[w_cnt[1:0]] = {8'h00, r_held[i]};
                        w_cnt               = w_cnt + 3'd1;
                    end
                end
                n_hc = 2'd0;
                n_el = u8u16_pkg::LEN_NONE;
            end
            if (i_byte[7] == 1'b0) begin
                if (w_cnt < 3'd4) begin
                    w_units[w_cnt[1:0]] = {8'h00, i_byte};
                    w_cnt               = w_cnt + 3'd1;
                end
            end else if (i_byte[7:5] == 3'b110) begin
                n_held[0] = i_byte;
                n_hc      = 2'd1;
                n_el      = u8u16_pkg::LEN_2;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_held[0] = i_byte;
                n_hc      = 2'd1;
                n_el      = u8u16_pkg::LEN_3;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_held[0] = i_byte;
                n_hc      = 2'd1;
                n_el      = u8u16_pkg::LEN_4;
            end else begin
                if (w_cnt < 3'd4) begin
                    w_units[w_cnt[1:0]] = {8'h00, i_byte};
                    w_cnt               = w_cnt + 3'd1;
                end
            end
        end

        // End of input closes whatever sequence is still open.
        if (i_eoi && n_hc != 2'd0) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_hc && w_cnt < 3'd4) begin
                    w_units[w_cnt[1:0]] = {8'h00, n_held[i]};
                    w_cnt               = w_cnt + 3'd1;
                end
            end
            n_hc = 2'd0;
            n_el = u8u16_pkg::LEN_NONE;
        end
    end

    assign o_res.units = w_units;
    assign o_res.count = w_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_hc   <= 2'd0;
            r_el   <= u8u16_pkg::LEN_NONE;
        end else if (i_fire) begin
            r_held <= n_held;
            r_hc   <= n_hc;
            r_el   <= n_el;
        end
    end

    `U8U16_ASSERT_ALWAYS(a_open_len, i_clk, i_rst_n, ((r_hc == 2'd0) == (r_el == 3'd0)), "held count and sequence length disagree")
    `U8U16_ASSERT_SAME(a_len_above_count, i_clk, i_rst_n, (r_hc != 2'd0), (r_el > {1'b0, r_hc}), "open sequence already complete")
    `U8U16_ASSERT_SAME(a_unit_bound, i_clk, i_rst_n, i_fire, (o_res.count <= 3'd4), "too many code units for one byte")

endmodule

// ===== sv/u8u16_out_buf.sv =====
`timescale 1ns / 1ps
`include "utf8_to_utf16_decoder_unit_assert.svh"

module u8u16_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  u8u16_pkg::t_result  i_res,
    input  logic                i_ready,
    output logic                o_can_load,
    output logic                o_valid,
    output logic [15:0]         o_unit,
    output logic                o_last
);

    logic [3:0][15:0] r_units;
    logic [2:0]       r_cnt;
    logic [1:0]       r_idx;
    logic             w_take;

    assign o_valid    = (r_cnt != 3'd0);
    assign w_take     = o_valid && i_ready;
    assign o_can_load = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready);
    assign o_unit     = r_units[r_idx];
    assign o_last     = (r_cnt == 3'd1);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_units <= i_res.units;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_res.count;
            r_idx <= 2'd0;
        end else if (w_take) begin
            r_cnt <= r_cnt - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    `U8U16_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, (({1'b0, r_idx} + r_cnt) <= 3'd4), "read position runs past buffered units")
    `U8U16_ASSERT_SAME(a_load_ok, i_clk, i_rst_n, i_load, o_can_load, "load while units remain")
    `U8U16_ASSERT_NEXT(a_drain, i_clk, i_rst_n, (w_take && o_last && !i_load), (r_cnt == 3'd0), "buffer not empty after its last transfer")

endmodule

// ===== tb/tb_utf8_to_utf16_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_utf8_to_utf16_decoder_unit;

    // A cycle with no transfer on either side counts toward this limit.
    // Even the slowest correct byte needs far fewer quiet cycles.
    localparam int QUIET_LIMIT = 500;

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
    } t_utf16_unit;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] in_byte
    logic        s_axis_tlast;   // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] code_unit
    logic        m_axis_tlast;   // last_of_run

    // Code units that the decoder still owes, oldest first.
    t_utf16_unit utf16_units_q[$];
    // Units produced by the byte that is being decoded right now.
    logic [15:0] byte_units[$];

    // Our own copy of the open multi-byte sequence.
    logic [7:0]  seq_bytes [3];
    logic [1:0]  seq_cnt;
    logic [2:0]  seq_len;

    int err_cnt = 0;
    int quiet_cycles = 0;
    int bytes_sent = 0;
    int rx_stall_left = 0;
    bit tx_idle_en;
    bit rx_idle_en;

    utf8_to_utf16_decoder_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // Every held byte comes out raw, zero-extended, and the sequence closes.
    function automatic void flush_seq();
        for (int i = 0; i < seq_cnt; i++) begin
            byte_units.push_back({8'h00, seq_bytes[i]});
        end
        seq_cnt = 2'd0;
        seq_len = u8u16_pkg::LEN_NONE;
    endfunction

    // A byte seen with no sequence open: either a lead byte that opens one,
    // or a unit of its own (ASCII, stray continuation byte, or 0xF8 to 0xFF).
    function automatic void start_or_pass(input logic [7:0] b);
        logic [2:0] len;
        if (!b[7]) begin
            len = u8u16_pkg::LEN_NONE;
        end else if (b[6:5] == 2'b10) begin
            len = u8u16_pkg::LEN_2;
        end else if (b[6:4] == 3'b110) begin
            len = u8u16_pkg::LEN_3;
        end else if (b[6:3] == 4'b1110) begin
            len = u8u16_pkg::LEN_4;
        end else begin
            len = u8u16_pkg::LEN_NONE;
        end
        if (len == u8u16_pkg::LEN_NONE) begin
            byte_units.push_back({8'h00, b});
        end else begin
            seq_bytes[0] = b;
            seq_cnt      = 2'd1;
            seq_len      = len;
        end
    endfunction

    // The final continuation byte completes the code point. A four-byte
    // sequence becomes a surrogate pair; the subtraction wraps, so overlong
    // and out-of-range code points still give a pair without any error.
    function automatic void complete_seq(input logic [7:0] b);
        logic [20:0] code_point;
        logic [20:0] offset;
        case (seq_len)
            u8u16_pkg::LEN_2: begin
                byte_units.push_back({5'd0, seq_bytes[0][4:0], b[5:0]});
            end
            u8u16_pkg::LEN_3: begin
                byte_units.push_back({seq_bytes[0][3:0], seq_bytes[1][5:0], b[5:0]});
            end
            default: begin
                code_point = {seq_bytes[0][2:0], seq_bytes[1][5:0],
                              seq_bytes[2][5:0], b[5:0]};
                offset     = code_point - u8u16_pkg::SUPP_OFFSET;
                byte_units.push_back({u8u16_pkg::SURR_HI_PREFIX, offset[19:10]});
                byte_units.push_back({u8u16_pkg::SURR_LO_PREFIX, code_point[9:0]});
            end
        endcase
        seq_cnt = 2'd0;
        seq_len = u8u16_pkg::LEN_NONE;
    endfunction

    // Works out the units that one accepted byte causes and queues them,
    // with the last flag on the final unit of the byte.
    function automatic void decode_utf8_byte(input logic [7:0] b, input logic eoi);
        byte_units.delete();
        if (seq_cnt == 2'd0) begin
            start_or_pass(b);
        end else if (b[7:6] != 2'b10) begin
            // A sequence broken by a non-continuation byte.
            flush_seq();
            start_or_pass(b);
        end else if (int'(seq_cnt) + 1 >= int'(seq_len)) begin
            complete_seq(b);
        end else begin
            seq_bytes[seq_cnt] = b;
            seq_cnt            = seq_cnt + 2'd1;
        end
        if (eoi && seq_cnt != 2'd0) begin
            flush_seq();
        end
        foreach (byte_units[i]) begin
            utf16_units_q.push_back('{unit: byte_units[i],
                                      last: (i == byte_units.size() - 1)});
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on every input transfer, checks every output transfer
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : monitor_check
        t_utf16_unit want;
        logic        in_xfer;
        logic        out_xfer;
        in_xfer  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_xfer = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (in_xfer) begin
            decode_utf8_byte(s_axis_tdata, s_axis_tlast);
        end
        if (out_xfer) begin
            if (utf16_units_q.size() == 0) begin
                err_cnt++;
                $display("%0t: code unit with none expected: expected none, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = utf16_units_q.pop_front();
                if (m_axis_tdata !== want.unit) begin
                    err_cnt++;
                    $display("%0t: code_unit mismatch: expected %h, actual %h",
                             $time, want.unit, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last) begin
                    err_cnt++;
                    $display("%0t: last_of_run mismatch: expected %b, actual %b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
        quiet_cycles = (in_xfer || out_xfer) ? 0 : quiet_cycles + 1;
    end

    // The watchdog ends a run that has stopped making progress.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_utf8_to_utf16_decoder_unit: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: back-pressure in random bursts of stall cycles
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            rx_stall_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one byte and returns at the edge where its transfer happens.
    // The valid stays high on return so that back-to-back bytes need no gap.
    task automatic send_byte(input logic [7:0] b, input logic eoi = 1'b0);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_bytes(input logic [7:0] seq[$], input logic eoi_on_last);
        foreach (seq[i]) begin
            send_byte(seq[i], eoi_on_last && (i == seq.size() - 1));
        end
    endtask

    // Holds the input off until every predicted unit has come out. The first
    // edge lets the monitor queue the units of the byte just sent.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (utf16_units_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // One character with random content. Most are well formed; some are
    // cut short, some are noise bytes, and now and then a byte ends the input.
    task automatic send_random_char();
        int         kind;
        int         len;
        int         conts;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        b    = $urandom_range(0, 255);
        if (kind <= 1) begin
            b[7] = 1'b0;
            send_byte(b, $urandom_range(0, 15) == 0);
        end else if (kind == 9) begin
            send_byte(b, $urandom_range(0, 15) == 0);
        end else begin
            len = (kind <= 3) ? 2 : (kind <= 5) ? 3 : 4;
            case (len)
                2:       b[7:5] = 3'b110;
                3:       b[7:4] = 4'b1110;
                default: b[7:3] = 5'b11110;
            endcase
            conts = len - 1;
            if ($urandom_range(0, 7) == 0) begin
                conts = $urandom_range(0, len - 2);
            end
            send_byte(b, $urandom_range(0, 15) == 0);
            repeat (conts) begin
                b      = $urandom_range(0, 255);
                b[7:6] = 2'b10;
                send_byte(b, $urandom_range(0, 15) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain ASCII and one well-formed sequence of each length.
    task automatic test_well_formed();
        send_byte(8'h00);
        send_bytes('{8'hDF, 8'hBF}, 1'b0);
        send_bytes('{8'hE2, 8'h82, 8'hAC}, 1'b0);
        send_bytes('{8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b0);
    endtask

    // Stray bytes, a broken four-byte sequence that flushes three held
    // bytes plus the new byte, a sequence closed by the end of input, an
    // overlong four-byte form, and a code point beyond the Unicode range.
    task automatic test_malformed();
        send_byte(8'h80);
        send_byte(8'hFF);
        send_bytes('{8'hF0, 8'h9F, 8'h98, 8'h41}, 1'b0);
        send_bytes('{8'hE2, 8'h82}, 1'b1);
        send_bytes('{8'hF0, 8'h80, 8'h80, 8'h80}, 1'b0);
        send_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b0);
    endtask

    task automatic test_random_stream(input int target);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        while (bytes_sent < target) send_random_char();
    endtask

    // The closing stretch runs at full rate on both sides.
    task automatic test_steady_stream(input int target);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (bytes_sent < target) send_random_char();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        seq_bytes     = '{default: 8'h00};
        seq_cnt       = 2'd0;
        seq_len       = u8u16_pkg::LEN_NONE;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_well_formed();
        test_malformed();
        wait_for_results();
        test_random_stream(290);
        wait_for_results();
        test_steady_stream(380);
        wait_for_results();
        repeat (8) @(posedge i_clk);

        if (err_cnt == 0 && utf16_units_q.size() == 0) begin
            $display("tb_utf8_to_utf16_decoder_unit: PASS");
        end else begin
            $display("tb_utf8_to_utf16_decoder_unit: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/u8u16_pkg.sv
sv/u8u16_core.sv
sv/u8u16_out_buf.sv
sv/utf8_to_utf16_decoder_unit.sv
tb/tb_utf8_to_utf16_decoder_unit.sv
